### hw/rtl/stf_pkg.sv
// shared types and constants of the source table rate filter
package stf_pkg;

  localparam int MAC_W      = 48;
  localparam int STAMP_W    = 32;
  localparam int LEN_W      = 12;
  localparam int PCOUNT_W   = 8;
  localparam int OP_W       = 3;
  localparam int GAP_W      = 20;
  localparam int SLOT_OUT_W = 6;
  localparam int KEPT_W     = 8;
  localparam int USE_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 12'd16;
  localparam logic [GAP_W-1:0] MIN_GAP_RESET = 20'd10000;

  // request operation codes
  localparam logic [OP_W-1:0] OP_FRAME      = 3'd0;
  localparam logic [OP_W-1:0] OP_ROUTER     = 3'd1;
  localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST_BEGIN = 3'd3;
  localparam logic [OP_W-1:0] OP_PEER       = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

endpackage

### hw/rtl/stf_ifs.sv
// channel interfaces of the source table rate filter

interface stf_in_if;
  logic                            valid;
  logic                            ready;
  logic [stf_pkg::OP_W-1:0]        op;
  logic [stf_pkg::MAC_W-1:0]       mac;
  logic [stf_pkg::STAMP_W-1:0]     stamp_us;
  logic [stf_pkg::LEN_W-1:0]       frame_len;
  logic [stf_pkg::PCOUNT_W-1:0]    peer_count;
  modport source (output valid, op, mac, stamp_us, frame_len, peer_count, input ready);
  modport sink   (input valid, op, mac, stamp_us, frame_len, peer_count, output ready);
endinterface

interface stf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            forward;
  logic [stf_pkg::SLOT_OUT_W-1:0]  slot;
  logic [stf_pkg::KEPT_W-1:0]      kept_len;
  logic [stf_pkg::USE_W-1:0]       sources_in_use;
  logic                            list_rejected;
  modport source (output valid, forward, slot, kept_len, sources_in_use, list_rejected,
                  input ready);
  modport sink   (input valid, forward, slot, kept_len, sources_in_use, list_rejected,
                  output ready);
endinterface

interface stf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [stf_pkg::CFG_IDX_W-1:0]   index;
  logic [stf_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/source_table_rate_filter.sv
// source table rate filter: top level with the slot memories and the scan sequencer
//
// usage:
//   in_req  carries one request: frame seen, router joined, disconnect, begin peer
//           list or peer entry. it is taken when valid and ready are both high.
//   out_rsp returns exactly one result per request, in request order.
//   cfg_wr  writes min_gap_us (index 0) or own_mac (index 1); it is always ready; it must
//           only be written while no request is in flight, the block does not enforce it.
// request flow:
//   a frame request walks the slot table, one slot per cycle, through the read port
//   of the address and time memories until the first matching slot or the last used
//   slot; short frames and all other requests go straight to the result stage.
//   one request is in work at a time; the next is taken the cycle after the last result moved into the output register.
// reset:
//   rst_n resets the state, table count, router state, list flag, own_mac, valid flags and min_gap_us;
//   the memories and payload registers are not cleared, slots at or above the count are never read.
// stall:
//   while out_rsp is stalled the output register holds; one more request can be
//   worked and then waits in the result stage until the output register frees.
module source_table_rate_filter #(
  parameter int PEER_SLOTS = 32,
  parameter int KEEP_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  stf_in_if.sink     in_req,
  stf_out_if.source  out_rsp,
  stf_cfg_if.sink    cfg_wr
);
  import stf_pkg::*;

  localparam int TABLE_SLOTS = PEER_SLOTS + 1;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0]      TABLE_SLOTS_C = CNT_W'(TABLE_SLOTS);
  localparam logic [PCOUNT_W:0]     PEER_LIMIT    = (PCOUNT_W + 1)'(PEER_SLOTS);
  localparam logic [LEN_W-1:0]      KEEP_LEN      = LEN_W'(KEEP_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } stf_state_t;

  // slot memories
  logic [MAC_W-1:0]   addr_mem [TABLE_SLOTS];
  logic [STAMP_W-1:0] time_mem [TABLE_SLOTS];

  stf_state_t state_r, state_nxt;

  // control state
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic              associated_r, associated_nxt;
  logic              list_ignored_r, list_ignored_nxt;
  logic [MAC_W-1:0]  router_addr_r, router_addr_nxt;
  logic [GAP_W-1:0]  min_gap_r;
  logic [MAC_W-1:0]  own_mac_r;

  // scan state
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [MAC_W-1:0]  mac_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [LEN_W-1:0]  flen_r;

  // memory read port
  logic              rd_en;
  logic [SLOT_W-1:0] rd_idx;
  logic [MAC_W-1:0]  addr_q_r;
  logic [STAMP_W-1:0] time_q_r;

  // memory write port
  logic               wr_addr_en, wr_time_en;
  logic [SLOT_W-1:0]  wr_idx;
  logic [MAC_W-1:0]   wr_addr_data;
  logic [STAMP_W-1:0] wr_time_data;

  // result stage
  logic              res_fwd_r, res_fwd_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [KEPT_W-1:0] res_kept_r, res_kept_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_fwd_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [KEPT_W-1:0] out_kept_r;
  logic [USE_W-1:0]  out_use_r;
  logic              out_rej_r;

  logic              in_fire, out_load;
  logic              hit;
  logic [STAMP_W-1:0] gap;
  logic [LEN_W-1:0]  kept_full;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_rsp.ready);

  // slot compare and wrapping gap of the slot read last cycle
  assign hit       = chk_valid_r && (addr_q_r == mac_r);
  assign gap       = stamp_r - time_q_r;
  assign kept_full = (flen_r < KEEP_LEN) ? flen_r : KEEP_LEN;

  always_comb begin
    state_nxt        = state_r;
    entry_count_nxt  = entry_count_r;
    associated_nxt   = associated_r;
    list_ignored_nxt = list_ignored_r;
    router_addr_nxt  = router_addr_r;
    idx_nxt          = idx_r;
    chk_valid_nxt    = 1'b0;
    chk_idx_nxt      = chk_idx_r;
    res_fwd_nxt      = res_fwd_r;
    res_slot_nxt     = res_slot_r;
    res_kept_nxt     = res_kept_r;
    rd_en            = 1'b0;
    rd_idx           = idx_r[SLOT_W-1:0];
    wr_addr_en       = 1'b0;
    wr_time_en       = 1'b0;
    wr_idx           = '0;
    wr_addr_data     = in_req.mac;
    wr_time_data     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_fwd_nxt  = 1'b0;
          res_slot_nxt = '0;
          res_kept_nxt = '0;
          idx_nxt      = '0;
          state_nxt    = ST_DONE;
          case (in_req.op)
            OP_FRAME: begin
              if (in_req.frame_len >= MIN_FRAME_LEN) begin
                state_nxt = ST_SCAN;
              end
            end
            OP_ROUTER: begin
              associated_nxt  = 1'b1;
              router_addr_nxt = in_req.mac;
              wr_addr_en      = 1'b1;
              wr_time_en      = 1'b1;
              if (entry_count_r == '0) begin
                entry_count_nxt = CNT_W'(1);
              end
            end
            OP_DISCONNECT: begin
              entry_count_nxt = '0;
              associated_nxt  = 1'b0;
            end
            OP_LIST_BEGIN: begin
              if ({1'b0, in_req.peer_count} > PEER_LIMIT) begin
                list_ignored_nxt = 1'b1;
              end else begin
                list_ignored_nxt = 1'b0;
                entry_count_nxt  = '0;
                if (associated_r) begin
                  // router stays in slot 0 and keeps its time
                  wr_addr_en      = 1'b1;
                  wr_addr_data    = router_addr_r;
                  entry_count_nxt = CNT_W'(1);
                end
              end
            end
            OP_PEER: begin
              if (!list_ignored_r && (in_req.mac != own_mac_r) &&
                  !(associated_r && (in_req.mac == router_addr_r)) &&
                  (entry_count_r < TABLE_SLOTS_C)) begin
                wr_addr_en      = 1'b1;
                wr_time_en      = 1'b1;
                wr_idx          = entry_count_r[SLOT_W-1:0];
                entry_count_nxt = entry_count_r + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // first matching slot ends the scan
          res_slot_nxt = chk_idx_r;
          if (gap >= STAMP_W'(min_gap_r)) begin
            res_fwd_nxt  = 1'b1;
            res_kept_nxt = kept_full[KEPT_W-1:0];
            wr_time_en   = 1'b1;
            wr_idx       = chk_idx_r;
            wr_time_data = stamp_r;
          end
          state_nxt = ST_DONE;
        end else if (idx_r < entry_count_r) begin
          rd_en         = 1'b1;
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = idx_r[SLOT_W-1:0];
          idx_nxt       = idx_r + CNT_W'(1);
        end else if (!chk_valid_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // slot memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_addr_en) begin
      addr_mem[wr_idx] <= wr_addr_data;
    end
    if (wr_time_en) begin
      time_mem[wr_idx] <= wr_time_data;
    end
    if (rd_en) begin
      addr_q_r <= addr_mem[rd_idx];
      time_q_r <= time_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      entry_count_r  <= '0;
      associated_r   <= 1'b0;
      list_ignored_r <= 1'b0;
      router_addr_r  <= '0;
      min_gap_r      <= MIN_GAP_RESET;
      own_mac_r      <= '0;
      chk_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      entry_count_r  <= entry_count_nxt;
      associated_r   <= associated_nxt;
      list_ignored_r <= list_ignored_nxt;
      router_addr_r  <= router_addr_nxt;
      chk_valid_r    <= chk_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          CFG_MIN_GAP: min_gap_r <= cfg_wr.data[GAP_W-1:0];
          CFG_OWN_MAC: own_mac_r <= cfg_wr.data[MAC_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    res_fwd_r  <= res_fwd_nxt;
    res_slot_r <= res_slot_nxt;
    res_kept_r <= res_kept_nxt;
    if (in_fire) begin
      mac_r   <= in_req.mac;
      stamp_r <= in_req.stamp_us;
      flen_r  <= in_req.frame_len;
    end
    if (out_load) begin
      out_fwd_r  <= res_fwd_r;
      out_slot_r <= SLOT_OUT_W'(res_slot_r);
      out_kept_r <= res_kept_r;
      out_use_r  <= USE_W'(entry_count_r);
      out_rej_r  <= list_ignored_r;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.forward        = out_fwd_r;
  assign out_rsp.slot           = out_slot_r;
  assign out_rsp.kept_len       = out_kept_r;
  assign out_rsp.sources_in_use = out_use_r;
  assign out_rsp.list_rejected  = out_rej_r;

endmodule

### verif/stf_result_checker.sv
// result checker of the source table rate filter: watches all channels, predicts and compares
module stf_result_checker
  import stf_pkg::*;
#(
  parameter int PEER_SLOTS = 32,
  parameter int KEEP_BYTES = 128
) (
  input  logic clk,
  input  logic rst_n,
  stf_in_if    req_mon,
  stf_out_if   rsp_mon,
  stf_cfg_if   cfg_mon,
  output int   mismatches,
  output int   results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = PEER_SLOTS + 1;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                  forward;
    logic [SLOT_OUT_W-1:0] slot;
    logic [KEPT_W-1:0]     kept_len;
    logic [USE_W-1:0]      sources_in_use;
    logic                  list_rejected;
  } filter_result_t;

  // predicted table and router state
  logic [MAC_W-1:0]   src_mac  [TABLE_SLOTS];
  logic [STAMP_W-1:0] fwd_time [TABLE_SLOTS];
  int unsigned        n_used;
  logic               joined;
  logic [MAC_W-1:0]   router_mac;
  logic               list_off;
  logic [GAP_W-1:0]   gap_floor;
  logic [MAC_W-1:0]   self_mac;

  filter_result_t     due_q[$];
  int unsigned        rsp_seen;

  // applies one request to the predicted state and returns its result
  function automatic filter_result_t filter_request(
    input logic [OP_W-1:0]     op,
    input logic [MAC_W-1:0]    mac,
    input logic [STAMP_W-1:0]  stamp,
    input logic [LEN_W-1:0]    flen,
    input logic [PCOUNT_W-1:0] pcount
  );
    filter_result_t     r;
    logic [STAMP_W-1:0] since;
    logic               hit;
    int unsigned        i;
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_FRAME: begin
        if (flen >= MIN_FRAME_LEN) begin
          for (i = 0; i < n_used; i++) begin
            if (!hit && src_mac[i] == mac) begin
              hit    = 1'b1;
              r.slot = SLOT_OUT_W'(i);
              since  = stamp - fwd_time[i];
              if (since >= STAMP_W'(gap_floor)) begin
                fwd_time[i] = stamp;
                r.forward   = 1'b1;
                r.kept_len  = (flen < KEEP_BYTES) ? KEPT_W'(flen) : KEPT_W'(KEEP_BYTES);
              end
            end
          end
        end
      end
      OP_ROUTER: begin
        joined      = 1'b1;
        router_mac  = mac;
        src_mac[0]  = mac;
        fwd_time[0] = '0;
        if (n_used == 0) n_used = 1;
      end
      OP_DISCONNECT: begin
        n_used = 0;
        joined = 1'b0;
      end
      OP_LIST_BEGIN: begin
        if (pcount > PEER_SLOTS) begin
          list_off = 1'b1;
        end else begin
          list_off = 1'b0;
          n_used   = 0;
          // router keeps slot 0 and its last forward time
          if (joined) begin
            src_mac[0] = router_mac;
            n_used     = 1;
          end
        end
      end
      OP_PEER: begin
        if (!list_off && mac != self_mac && !(joined && mac == router_mac) &&
            n_used < TABLE_SLOTS) begin
          src_mac[n_used]  = mac;
          fwd_time[n_used] = '0;
          n_used++;
        end
      end
      default: begin
      end
    endcase
    r.sources_in_use = USE_W'(n_used);
    r.list_rejected  = list_off;
    return r;
  endfunction

  always @(posedge clk) begin
    filter_result_t want, got;
    if (!rst_n) begin
      n_used     = 0;
      joined     = 1'b0;
      router_mac = '0;
      list_off   = 1'b0;
      gap_floor  = MIN_GAP_RESET;
      self_mac   = '0;
      rsp_seen   = 0;
      mismatches = 0;
      due_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_MIN_GAP) gap_floor = cfg_mon.data[GAP_W-1:0];
        else if (cfg_mon.index == CFG_OWN_MAC) self_mac = cfg_mon.data[MAC_W-1:0];
      end
      if (req_mon.valid && req_mon.ready) begin
        due_q.push_back(filter_request(req_mon.op, req_mon.mac, req_mon.stamp_us,
                                       req_mon.frame_len, req_mon.peer_count));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.forward        = rsp_mon.forward;
        got.slot           = rsp_mon.slot;
        got.kept_len       = rsp_mon.kept_len;
        got.sources_in_use = rsp_mon.sources_in_use;
        got.list_rejected  = rsp_mon.list_rejected;
        if (due_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("stf check: result %0d arrived with no request pending", rsp_seen);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            if (mismatches < REPORT_MAX)
              $display({"stf check: result %0d expected fwd=%0d slot=%0d len=%0d used=%0d ",
                        "rej=%0d, got fwd=%0d slot=%0d len=%0d used=%0d rej=%0d"},
                       rsp_seen, want.forward, want.slot, want.kept_len,
                       want.sources_in_use, want.list_rejected, got.forward, got.slot,
                       got.kept_len, got.sources_in_use, got.list_rejected);
            mismatches++;
          end
        end
        rsp_seen++;
      end
    end
    results_due <= due_q.size();
  end

endmodule

### verif/tb.sv
// testbench top: clock, reset, request and register stimulus, result back-pressure, verdict
module tb
  import stf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PEER_SLOTS    = 32;
  localparam int KEEP_BYTES    = 128;
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 18;
  localparam int PHASES        = 5;
  localparam int PHASE_REQS    = 345;
  localparam int STEADY_PHASE  = 2;
  localparam int POOL_N        = 12;
  localparam int TAIL_CYCLES   = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // long receiver hold-off so the block fills up and stalls its input
  localparam int FIRST_HOLD_AT = 500;
  localparam int HOLD_SPACING  = 700;
  localparam int HOLD_CYCLES   = 400;

  // ops the block does not use
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [MAC_W-1:0] MAC_ALL_ONES = '1;
  localparam logic [MAC_W-1:0] MAC_LOW_BIT  = 48'h0000_0000_0001;
  localparam logic [MAC_W-1:0] MAC_TOP_BIT  = 48'h8000_0000_0000;

  logic clk = 1'b0;
  logic rst_n;

  stf_in_if  in_req ();
  stf_out_if out_rsp ();
  stf_cfg_if cfg_wr ();

  int          mismatches;
  int          results_due;
  int unsigned issued = 0;      // requests accepted, stimulus side
  int unsigned sent_cnt = 0;    // same count, seen by the receiver
  int unsigned cycle_cnt = 0;
  int unsigned hold_left;
  int unsigned next_hold_at;
  logic        steady = 1'b0;   // no random idling on either side while set

  // stimulus state: current settings, source pool, running receive clock
  int unsigned        cur_gap;
  logic [MAC_W-1:0]   own_now;
  logic [MAC_W-1:0]   router_now;
  logic [STAMP_W-1:0] now_us;
  logic [MAC_W-1:0]   src_pool [POOL_N];

  source_table_rate_filter #(
    .PEER_SLOTS (PEER_SLOTS),
    .KEEP_BYTES (KEEP_BYTES)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  stf_result_checker #(
    .PEER_SLOTS (PEER_SLOTS),
    .KEEP_BYTES (KEEP_BYTES)
  ) i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (in_req),
    .rsp_mon     (out_rsp),
    .cfg_mon     (cfg_wr),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // result side: random idling, none while steady, and long hold-offs counted here, also while steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      hold_left     <= 0;
      next_hold_at  <= FIRST_HOLD_AT;
    end else if (hold_left != 0) begin
      out_rsp.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (sent_cnt >= next_hold_at) begin
      out_rsp.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      next_hold_at  <= next_hold_at + HOLD_SPACING;
    end else begin
      out_rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  // mostly known sources, some strangers
  function automatic logic [MAC_W-1:0] pick_source();
    if ($urandom_range(9) == 0) return rand_mac();
    return src_pool[$urandom_range(POOL_N - 1)];
  endfunction

  // short, kept whole, and clamped lengths
  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 2) return LEN_W'($urandom_range(15));
    else if (pick < 7) return LEN_W'($urandom_range(128, 16));
    return LEN_W'($urandom_range(4095, 129));
  endfunction

  // offers one request and waits for it to be taken; called at a rising edge
  task automatic send(
    input logic [OP_W-1:0]     op,
    input logic [MAC_W-1:0]    mac,
    input logic [STAMP_W-1:0]  stamp,
    input logic [LEN_W-1:0]    flen,
    input logic [PCOUNT_W-1:0] pcount
  );
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.op         <= op;
    in_req.mac        <= mac;
    in_req.stamp_us   <= stamp;
    in_req.frame_len  <= flen;
    in_req.peer_count <= pcount;
    do @(posedge clk); while (!in_req.ready);
    issued++;
    sent_cnt <= issued;
  endtask

  // non-frame request with random filler in the unused fields
  task automatic send_op(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                         input logic [PCOUNT_W-1:0] pcount);
    send(op, mac, $urandom, rand_len(), pcount);
  endtask

  // register write once every result has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_req.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
  endtask

  // random traffic: mostly well-formed peer lists followed by frame bursts
  task automatic run_traffic(input int unsigned n_req);
    int unsigned      stop_at, kind, cnt, j;
    logic [MAC_W-1:0] m;
    stop_at = issued + n_req;
    while (issued < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        router_now = pick_source();
        send_op(OP_ROUTER, router_now, PCOUNT_W'($urandom));
      end else if (kind < 9) begin
        send_op(OP_DISCONNECT, rand_mac(), PCOUNT_W'($urandom));
      end else if (kind < 27) begin
        cnt = $urandom_range(PEER_SLOTS);
        send_op(OP_LIST_BEGIN, rand_mac(), PCOUNT_W'(cnt));
        // sometimes more entries than fit, to reach a full table
        if ($urandom_range(3) == 0) cnt = $urandom_range(40, 30);
        for (j = 0; j < cnt; j++) begin
          kind = $urandom_range(19);
          if (kind == 0) m = own_now;
          else if (kind == 1) m = router_now;
          else m = pick_source();
          send_op(OP_PEER, m, PCOUNT_W'($urandom));
        end
      end else if (kind < 32) begin
        // list announced too long, its entries must be dropped
        send_op(OP_LIST_BEGIN, rand_mac(), PCOUNT_W'($urandom_range(255, PEER_SLOTS + 1)));
        cnt = $urandom_range(4);
        for (j = 0; j < cnt; j++) send_op(OP_PEER, pick_source(), PCOUNT_W'($urandom));
      end else if (kind < 36) begin
        send(OP_W'($urandom), rand_mac(), $urandom, LEN_W'($urandom), PCOUNT_W'($urandom));
      end else begin
        cnt = $urandom_range(12, 3);
        for (j = 0; j < cnt; j++) begin
          if ($urandom_range(19) == 0) now_us = $urandom;
          else now_us = now_us + $urandom_range(cur_gap / 2 + 1);
          send(OP_FRAME, pick_source(), now_us, rand_len(), PCOUNT_W'($urandom));
        end
      end
    end
  endtask

  initial begin : stimulus
    int ph, k;
    rst_n             <= 1'b0;
    in_req.valid      <= 1'b0;
    in_req.op         <= OP_FRAME;
    in_req.mac        <= '0;
    in_req.stamp_us   <= '0;
    in_req.frame_len  <= '0;
    in_req.peer_count <= '0;
    cfg_wr.valid      <= 1'b0;
    cfg_wr.index      <= CFG_MIN_GAP;
    cfg_wr.data       <= '0;
    router_now = '0;
    own_now    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings: gap 10000, own address zero
    send(OP_FRAME, '0, '0, 12'd16, '0);                      // empty table
    send(OP_PEER, '0, '1, '1, '1);                            // own address skipped
    send_op(OP_ROUTER, MAC_ALL_ONES, '0);
    send(OP_FRAME, MAC_ALL_ONES, 32'd0, '1, '0);             // too soon after join
    send(OP_FRAME, MAC_ALL_ONES, 32'd20000, 12'd15, '0);     // short frame
    send(OP_FRAME, MAC_ALL_ONES, 32'd10000, 12'd16, '0);     // gap exactly at minimum
    send(OP_FRAME, MAC_ALL_ONES, 32'd19999, 12'd200, '0);    // one under minimum
    send_op(OP_LIST_BEGIN, '0, 8'd32);                       // at the limit, router kept
    send_op(OP_PEER, MAC_ALL_ONES, '0);                      // router skipped
    send_op(OP_PEER, MAC_LOW_BIT, '0);
    send_op(OP_PEER, MAC_TOP_BIT, '0);
    send(OP_FRAME, MAC_LOW_BIT, '1, 12'd128, '0);
    send(OP_FRAME, MAC_LOW_BIT, 32'd9999, 12'd129, '0);      // gap wraps, clamped
    send(OP_FRAME, MAC_TOP_BIT, 32'd0, 12'd17, '0);          // too soon, slot named
    send(OP_FRAME, 48'h2, 32'd50000, 12'd64, '0);            // unknown source
    send_op(OP_LIST_BEGIN, '0, 8'd33);                       // over the limit
    send_op(OP_PEER, 48'h3, '0);                             // ignored while rejected
    send_op(OP_LIST_BEGIN, '1, '1);
    send_op(OP_LIST_BEGIN, '0, '0);                          // accepted, empty list
    send_op(OP_DISCONNECT, '0, '0);
    send_op(OP_PEER, MAC_ALL_ONES, '0);                      // no router now, appended
    send(OP_FRAME, MAC_ALL_ONES, 32'h8000_0000, 12'd100, '0);
    for (k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++) send(OP_W'(k), '1, '1, '1, '1);
    send_op(OP_ROUTER, '0, '0);                              // count already set

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          cur_gap = 0;
          own_now = '1;
        end
        1: begin
          cur_gap = 1_000_000;
          own_now = rand_mac();
        end
        2: begin
          cur_gap = 1;
          own_now = rand_mac();
        end
        3: begin
          cur_gap = $urandom_range(1_000_000);
          own_now = '0;
        end
        default: begin
          cur_gap = 10_000;
          own_now = rand_mac();
        end
      endcase
      write_reg(CFG_MIN_GAP, CFG_DATA_W'(cur_gap));
      write_reg(CFG_OWN_MAC, own_now);
      for (k = 0; k < POOL_N; k++) src_pool[k] = rand_mac();
      // own address shows up among the sources as well
      src_pool[0] = own_now;
      // large gap runs close to the top so the receive clock wraps
      now_us = (ph == 1) ? 32'hFFF0_0000 : $urandom;
      steady <= (ph == STEADY_PHASE);
      run_traffic(PHASE_REQS);
    end

    steady       <= 1'b0;
    in_req.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
